// ----- rtl/esd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esd_pkg
// Types, constants and decode helpers shared by the escape sequence decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

  localparam int X_HEX_DIGITS_DEF = 2;
  localparam int U_HEX_DIGITS_DEF = 3;

  localparam int CHAR_W   = 8;
  localparam int CODE_W   = 12;
  localparam int STATUS_W = 2;
  localparam int VALUE_W  = 16;

  // Result queue depth; one decoded byte can push two results.
  localparam int FIFO_DEPTH = 4;

  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t STATUS_OK      = 2'd0;
  localparam status_t STATUS_INVALID = 2'd1;
  localparam status_t STATUS_RANGE   = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CHAR_X         = 8'h78;
  localparam logic [CHAR_W-1:0] CHAR_U         = 8'h75;
  localparam logic [CHAR_W-1:0] CHAR_ZERO      = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_SEVEN     = 8'h37;

  localparam logic [VALUE_W-1:0] CODE_MAX   = 16'h0FFF;
  localparam logic [VALUE_W-1:0] NARROW_MAX = 16'h00FF;

  typedef struct packed {
    logic [CODE_W-1:0] code_point;
    status_t           status;
    logic              last;
  } result_t;

  // Up to two results produced by one processed item.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } digit_t;

  typedef struct packed {
    logic       valid;
    logic [6:0] code;
  } simple_t;

  function automatic digit_t hex_digit(input logic [CHAR_W-1:0] c);
    digit_t d;
    d = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.valid = 1'b1;
      d.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d.valid = 1'b1;
      d.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.valid = 1'b1;
      d.value = 4'(c - 8'h37);
    end
    return d;
  endfunction

  function automatic simple_t simple_escape(input logic [CHAR_W-1:0] c);
    simple_t s;
    s.valid = 1'b1;
    case (c)
      8'h61:   s.code = 7'd7;
      8'h6E:   s.code = 7'd10;
      8'h74:   s.code = 7'd9;
      8'h76:   s.code = 7'd11;
      8'h62:   s.code = 7'd8;
      8'h72:   s.code = 7'd13;
      8'h66:   s.code = 7'd12;
      8'h3F:   s.code = 7'd63;
      8'h5C:   s.code = 7'd92;
      8'h27:   s.code = 7'd39;
      8'h22:   s.code = 7'd34;
      default: begin
        s.valid = 1'b0;
        s.code  = 7'd0;
      end
    endcase
    return s;
  endfunction

  // A numeric value becomes a result, or a range error when it does not fit.
  function automatic result_t encode_value(input logic [VALUE_W-1:0] v,
                                           input logic narrow);
    result_t r;
    r = '0;
    if (v > CODE_MAX || (narrow && v > NARROW_MAX)) begin
      r.status = STATUS_RANGE;
    end else begin
      r.code_point = CODE_W'(v);
      r.status     = STATUS_OK;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/esd_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esd_fifo
// Small result queue: takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module esd_fifo (
  input  wire                  clk,
  input  wire                  rst,
  input  esd_pkg::push_t       push,
  output logic                 room,
  output logic                 out_valid,
  input  wire                  out_ready,
  output esd_pkg::result_t     out_data
);

  localparam int DEPTH = esd_pkg::FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  esd_pkg::result_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;
  logic [PTR_W-1:0] wr_ptr_inc;

  assign pop        = out_valid && out_ready;
  assign out_valid  = (count != '0);
  assign out_data   = mem[rd_ptr];
  assign room       = (count <= CNT_W'(DEPTH - 2));
  assign wr_ptr_inc = wr_ptr + PTR_W'(1);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_inc] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> room)
    else $error("result pushed without room in the queue");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    pop && push.count == 2'd0 |=> count == $past(count) - CNT_W'(1))
    else $error("queue count did not follow a lone pop");

endmodule
`default_nettype wire

// ----- rtl/esd_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esd_core
// Input register, escape state and single-pass decode of one byte.
// ----------------------------------------------------------------------------
module esd_core #(
  parameter int X_HEX_DIGITS = esd_pkg::X_HEX_DIGITS_DEF,
  parameter int U_HEX_DIGITS = esd_pkg::U_HEX_DIGITS_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire [esd_pkg::CHAR_W-1:0]     in_char,
  input  wire                           in_eot,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire                           cfg_data,
  input  wire                           room,
  output esd_pkg::push_t                push
);

  localparam int MAX_HEX = (X_HEX_DIGITS > U_HEX_DIGITS) ? X_HEX_DIGITS : U_HEX_DIGITS;
  localparam int HEX_W   = 4 * MAX_HEX;
  localparam int ACC_W   = (HEX_W > 9) ? HEX_W : 9;

  typedef enum logic [4:0] {
    PH_PLAIN     = 5'b00001,
    PH_ESC       = 5'b00010,
    PH_HEX_FIRST = 5'b00100,
    PH_HEX_MORE  = 5'b01000,
    PH_OCT       = 5'b10000
  } phase_t;

  phase_t                     phase;
  phase_t                     phase_next;
  logic [ACC_W-1:0]           acc;
  logic [ACC_W-1:0]           acc_next;
  logic [ACC_W-1:0]           acc_grow;
  logic [1:0]                 digits_left;
  logic [1:0]                 digits_left_next;
  logic                       narrow;
  logic                       held;
  logic [esd_pkg::CHAR_W-1:0] held_char;
  logic                       held_eot;
  logic                       fire;
  esd_pkg::push_t             step;
  esd_pkg::digit_t            hex;
  esd_pkg::simple_t           simple;
  logic                       oct_ok;
  logic [2:0]                 oct_val;
  logic                       more_ok;
  logic [1:0]                 dl_dec;
  esd_pkg::result_t           plain_res;
  esd_pkg::result_t           err_res;

  assign fire      = held && room;
  assign in_ready  = !held || fire;
  assign cfg_ready = 1'b1;
  assign push      = fire ? step : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      narrow <= 1'b0;
    end else if (cfg_valid) begin
      narrow <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_char <= in_char;
      held_eot  <= in_eot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_PLAIN;
      acc         <= '0;
      digits_left <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      acc         <= acc_next;
      digits_left <= digits_left_next;
    end
  end

  assign hex     = esd_pkg::hex_digit(held_char);
  assign simple  = esd_pkg::simple_escape(held_char);
  assign oct_ok  = held_char >= esd_pkg::CHAR_ZERO && held_char <= esd_pkg::CHAR_SEVEN;
  assign oct_val = held_char[2:0];
  assign more_ok = (phase == PH_HEX_MORE) ? hex.valid : oct_ok;
  assign dl_dec  = digits_left - 2'd1;
  assign acc_grow = (phase == PH_HEX_MORE) ? ((acc << 4) + ACC_W'(hex.value))
                                           : ((acc << 3) + ACC_W'(oct_val));

  always_comb begin
    plain_res            = '0;
    plain_res.code_point = esd_pkg::CODE_W'(held_char);
    plain_res.status     = esd_pkg::STATUS_OK;
    err_res              = '0;
    err_res.status       = esd_pkg::STATUS_INVALID;
  end

  always_comb begin
    phase_next       = phase;
    acc_next         = acc;
    digits_left_next = digits_left;
    step             = '0;
    if (held_eot) begin
      // End of text flushes whatever escape is open.
      phase_next       = PH_PLAIN;
      acc_next         = '0;
      digits_left_next = '0;
      case (phase)
        PH_ESC, PH_HEX_FIRST: begin
          step.count = 2'd1;
          step.r0    = err_res;
        end
        PH_HEX_MORE, PH_OCT: begin
          step.count = 2'd1;
          step.r0    = esd_pkg::encode_value(esd_pkg::VALUE_W'(acc), narrow);
        end
        default: begin
          step.count = 2'd0;
        end
      endcase
    end else begin
      case (phase)
        PH_PLAIN: begin
          if (held_char == esd_pkg::CHAR_BACKSLASH) begin
            phase_next = PH_ESC;
          end else begin
            step.count = 2'd1;
            step.r0    = plain_res;
          end
        end
        PH_ESC: begin
          if (simple.valid) begin
            step.count           = 2'd1;
            step.r0.code_point   = esd_pkg::CODE_W'(simple.code);
            step.r0.status       = esd_pkg::STATUS_OK;
            phase_next           = PH_PLAIN;
          end else if (held_char == esd_pkg::CHAR_X) begin
            phase_next       = PH_HEX_FIRST;
            digits_left_next = 2'(X_HEX_DIGITS - 1);
          end else if (held_char == esd_pkg::CHAR_U) begin
            phase_next       = PH_HEX_FIRST;
            digits_left_next = 2'(U_HEX_DIGITS - 1);
          end else if (oct_ok) begin
            phase_next       = PH_OCT;
            acc_next         = ACC_W'(oct_val);
            digits_left_next = 2'd2;
          end else begin
            step.count = 2'd1;
            step.r0    = err_res;
            phase_next = PH_PLAIN;
          end
        end
        PH_HEX_FIRST: begin
          if (!hex.valid) begin
            step.count       = 2'd1;
            step.r0          = err_res;
            phase_next       = PH_PLAIN;
            acc_next         = '0;
            digits_left_next = '0;
          end else if (digits_left == 2'd0) begin
            step.count       = 2'd1;
            step.r0          = esd_pkg::encode_value(esd_pkg::VALUE_W'(hex.value), narrow);
            phase_next       = PH_PLAIN;
            acc_next         = '0;
          end else begin
            acc_next   = ACC_W'(hex.value);
            phase_next = PH_HEX_MORE;
          end
        end
        PH_HEX_MORE, PH_OCT: begin
          acc_next         = '0;
          digits_left_next = '0;
          phase_next       = PH_PLAIN;
          if (more_ok) begin
            if (dl_dec == 2'd0) begin
              step.count = 2'd1;
              step.r0    = esd_pkg::encode_value(esd_pkg::VALUE_W'(acc_grow), narrow);
            end else begin
              acc_next         = acc_grow;
              digits_left_next = dl_dec;
              phase_next       = phase;
            end
          end else begin
            // The value is emitted, then the terminating byte is taken as text.
            step.r0 = esd_pkg::encode_value(esd_pkg::VALUE_W'(acc), narrow);
            if (held_char == esd_pkg::CHAR_BACKSLASH) begin
              step.count = 2'd1;
              phase_next = PH_ESC;
            end else begin
              step.count = 2'd2;
              step.r1    = plain_res;
            end
          end
        end
        default: begin
          phase_next       = PH_PLAIN;
          acc_next         = '0;
          digits_left_next = '0;
        end
      endcase
    end
    step.r0.last = (step.count == 2'd1);
    step.r1.last = (step.count == 2'd2);
  end

  a_eot_plain: assert property (@(posedge clk) disable iff (rst)
    fire && held_eot |=> phase == PH_PLAIN && acc == '0)
    else $error("end of text left an escape open");

  a_two_numeric: assert property (@(posedge clk) disable iff (rst)
    fire && step.count == 2'd2 |-> (phase == PH_HEX_MORE || phase == PH_OCT))
    else $error("two results outside a numeric escape");

  a_plain_clean: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PLAIN |-> digits_left == 2'd0 && acc == '0)
    else $error("escape state left over in plain text");

endmodule
`default_nettype wire

// ----- rtl/escape_sequence_decoder_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escape_sequence_decoder_top
// Decodes the body of a C character or string literal into code points.
// ----------------------------------------------------------------------------
// Each request on the input stream is one byte of literal text, or, with
// tlast high, the end of the text, which flushes an open escape. A byte
// is registered on acceptance and decoded from that register by a single
// pass of logic into zero, one or two results, which enter a four-entry
// result queue; the last result of each request carries tlast. One request is
// taken every cycle while the queue holds at most two results, so a stream
// whose bytes yield one result each runs at one byte per clock while the
// output is ready, and only a byte that ends a numeric escape and is itself
// taken as plain text pushes two results. A result passes the input register
// and then the result queue. The narrow_chars register is written through the cfg channel,
// which is always ready, and should be changed only while the block is idle.
// ----------------------------------------------------------------------------
module escape_sequence_decoder_top #(
  parameter int X_HEX_DIGITS = esd_pkg::X_HEX_DIGITS_DEF,
  parameter int U_HEX_DIGITS = esd_pkg::U_HEX_DIGITS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] char_in
  input  wire         s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [11:0] code_point, [13:12] status, zero fill
  output logic        m_axis_tlast,   // last
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire         cfg_data        // narrow_chars
);

  esd_pkg::push_t   push;
  esd_pkg::result_t head;
  logic             room;

  esd_core #(
    .X_HEX_DIGITS (X_HEX_DIGITS),
    .U_HEX_DIGITS (U_HEX_DIGITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_char   (s_axis_tdata),
    .in_eot    (s_axis_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .room      (room),
    .push      (push)
  );

  esd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (head)
  );

  assign m_axis_tdata = {2'b00, head.status, head.code_point};
  assign m_axis_tlast = head.last;

endmodule
`default_nettype wire

// ----- dv/tb_escape_sequence_decoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_escape_sequence_decoder_top
// Self-checking bench for the escape sequence decoder. Literal text requests
// go in through the input stream. A behavioral decoder inside the bench
// predicts every result. Each result taken from the output stream is checked
// field by field against the oldest prediction. The run steps through narrow
// and wide modes and through several patterns of source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_escape_sequence_decoder_top;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 11;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 10;

  localparam logic [7:0] SIMPLE_CHARS [11] = '{"a", "n", "t", "v", "b", "r", "f", "?",
                                               "\\", "'", "\""};
  localparam esd_pkg::result_t BAD_ESCAPE = '{code_point: '0,
                                              status: esd_pkg::STATUS_INVALID,
                                              last: 1'b0};

  typedef enum logic [4:0] {
    DEC_PLAIN     = 5'b00001,
    DEC_ESC       = 5'b00010,
    DEC_HEX_FIRST = 5'b00100,
    DEC_HEX_MORE  = 5'b01000,
    DEC_OCT       = 5'b10000
  } dec_phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } text_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  text_req_t          text_q[$];
  esd_pkg::result_t   decoded_q[$];
  int          queued_cnt = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  logic        hold_go = 1'b0;
  int          hold_left = 0;
  int          cycle_cnt = 0;

  int          fail_cnt = 0;
  int          req_cnt = 0;
  int          eot_cnt = 0;
  int          result_cnt = 0;
  int          ok_cnt = 0;
  int          invalid_cnt = 0;
  int          range_cnt = 0;

  // Behavioral decoder state, updated as requests are accepted.
  dec_phase_t  dec_phase = DEC_PLAIN;
  logic [15:0] dec_acc = '0;
  logic [1:0]  dec_left = '0;
  logic        narrow_mode = 1'b0;

  escape_sequence_decoder_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] char_in
    .s_axis_tlast  (s_axis_tlast),   // end_of_text
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [11:0] code_point, [13:12] status, zero fill
    .m_axis_tlast  (m_axis_tlast),   // last
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)        // narrow_chars
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------- decoding

  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic int simple_code(input logic [7:0] c);
    case (c)
      "a":     return 7;
      "n":     return 10;
      "t":     return 9;
      "v":     return 11;
      "b":     return 8;
      "r":     return 13;
      "f":     return 12;
      "?":     return 63;
      "\\":    return 92;
      "'":     return 39;
      "\"":    return 34;
      default: return -1;
    endcase
  endfunction

  function automatic esd_pkg::result_t value_result(input logic [15:0] v);
    esd_pkg::result_t r;
    r = '0;
    if (v > 16'h0FFF || (narrow_mode && v > 16'h00FF)) begin
      r.status = esd_pkg::STATUS_RANGE;
    end else begin
      r.code_point = v[11:0];
      r.status     = esd_pkg::STATUS_OK;
    end
    return r;
  endfunction

  function automatic void back_to_text();
    dec_phase = DEC_PLAIN;
    dec_acc   = '0;
    dec_left  = '0;
  endfunction

  // An ordinary byte passes through; a backslash opens an escape instead.
  function automatic logic text_char(input logic [7:0] c, output esd_pkg::result_t r);
    r = value_result({8'h00, c});
    if (c == esd_pkg::CHAR_BACKSLASH) begin
      dec_phase = DEC_ESC;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic decode_request(input logic [7:0] c, input logic eot);
    esd_pkg::result_t res [2];
    esd_pkg::result_t r;
    int      n;
    int      d;
    n      = 0;
    res[0] = '0;
    res[1] = '0;
    if (eot) begin
      if (dec_phase == DEC_ESC || dec_phase == DEC_HEX_FIRST) begin
        res[0] = BAD_ESCAPE;
        n      = 1;
      end else if (dec_phase == DEC_HEX_MORE || dec_phase == DEC_OCT) begin
        res[0] = value_result(dec_acc);
        n      = 1;
      end
      back_to_text();
    end else begin
      case (dec_phase)
        DEC_PLAIN: begin
          if (text_char(c, r)) begin
            res[0] = r;
            n      = 1;
          end
        end
        DEC_ESC: begin
          d = simple_code(c);
          if (d >= 0) begin
            res[0] = value_result(16'(d));
            n      = 1;
            back_to_text();
          end else if (c == esd_pkg::CHAR_X) begin
            dec_phase = DEC_HEX_FIRST;
            dec_left  = 2'(esd_pkg::X_HEX_DIGITS_DEF - 1);
          end else if (c == esd_pkg::CHAR_U) begin
            dec_phase = DEC_HEX_FIRST;
            dec_left  = 2'(esd_pkg::U_HEX_DIGITS_DEF - 1);
          end else if (c >= esd_pkg::CHAR_ZERO && c <= esd_pkg::CHAR_SEVEN) begin
            dec_phase = DEC_OCT;
            dec_acc   = 16'(c - esd_pkg::CHAR_ZERO);
            dec_left  = 2'd2;
          end else begin
            res[0] = BAD_ESCAPE;
            n      = 1;
            back_to_text();
          end
        end
        DEC_HEX_FIRST: begin
          d = hex_val(c);
          if (d < 0) begin
            res[0] = BAD_ESCAPE;
            n      = 1;
            back_to_text();
          end else begin
            dec_acc = 16'(d);
            if (dec_left == 2'd0) begin
              res[0] = value_result(dec_acc);
              n      = 1;
              back_to_text();
            end else begin
              dec_phase = DEC_HEX_MORE;
            end
          end
        end
        default: begin
          if (dec_phase == DEC_HEX_MORE) d = hex_val(c);
          else if (c >= esd_pkg::CHAR_ZERO && c <= esd_pkg::CHAR_SEVEN)
            d = int'(c - esd_pkg::CHAR_ZERO);
          else d = -1;
          if (d >= 0) begin
            if (dec_phase == DEC_HEX_MORE) dec_acc = {dec_acc[11:0], 4'(d)};
            else dec_acc = {dec_acc[12:0], 3'(d)};
            dec_left = dec_left - 2'd1;
            if (dec_left == 2'd0) begin
              res[0] = value_result(dec_acc);
              n      = 1;
              back_to_text();
            end
          end else begin
            // The value goes out first, then the terminating byte as text.
            res[0] = value_result(dec_acc);
            n      = 1;
            back_to_text();
            if (text_char(c, r)) begin
              res[1] = r;
              n      = 2;
            end
          end
        end
      endcase
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) decoded_q.push_back(res[i]);
  endtask

  task automatic note_failure(input string what, input esd_pkg::result_t want,
                              input esd_pkg::result_t got);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) begin
      $display("%0t %s: expected code %03h status %0d last %0b,",
               $time, what, want.code_point, want.status, want.last,
               " got code %03h status %0d last %0b",
               got.code_point, got.status, got.last);
    end
  endtask

  // Checks results, then follows accepted requests and register writes.
  always @(posedge clk) begin
    esd_pkg::result_t got;
    esd_pkg::result_t want;
    if (rst) begin
      narrow_mode = 1'b0;
      back_to_text();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.code_point = m_axis_tdata[11:0];
        got.status     = m_axis_tdata[13:12];
        got.last       = m_axis_tlast;
        result_cnt++;
        if (got.status == esd_pkg::STATUS_OK) ok_cnt++;
        else if (got.status == esd_pkg::STATUS_INVALID) invalid_cnt++;
        else range_cnt++;
        if (decoded_q.size() == 0) begin
          note_failure("Unexpected result", '0, got);
        end else begin
          want = decoded_q.pop_front();
          if (got.code_point !== want.code_point || got.status !== want.status ||
              got.last !== want.last) begin
            note_failure("Result mismatch", want, got);
          end
        end
      end
      if (cfg_valid && cfg_ready) narrow_mode = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        req_cnt++;
        if (s_axis_tlast) eot_cnt++;
        decode_request(s_axis_tdata, s_axis_tlast);
      end
    end
  end

  // ---------------------------------------------------------- stream drivers

  always @(posedge clk) begin
    text_req_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (text_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        nxt = text_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.ch;
        s_axis_tlast  <= nxt.eot;
      end else begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'($urandom);
        s_axis_tlast  <= 1'($urandom);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Long sink hold-off, so the result queue fills and the input backs up.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_cnt, decoded_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ----------------------------------------------------------------- stimulus

  task automatic push_byte(input logic [7:0] c);
    text_q.push_back('{ch: c, eot: 1'b0});
    queued_cnt++;
  endtask

  task automatic push_end();
    text_q.push_back('{ch: 8'($urandom), eot: 1'b1});
    queued_cnt++;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input int v);
    if (v < 10) return esd_pkg::CHAR_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(v - 10);
  endfunction

  function automatic logic [7:0] oct_char();
    return esd_pkg::CHAR_ZERO + 8'($urandom_range(0, 7));
  endfunction

  // Mostly well-formed escapes with random content; short numeric escapes
  // end on whatever the next sequence starts with.
  task automatic add_random(input int count);
    int stop;
    int kind;
    stop = queued_cnt + count;
    while (queued_cnt < stop) begin
      kind = $urandom_range(0, 99);
      if (kind < 28) begin
        push_byte(8'($urandom));
      end else if (kind < 42) begin
        push_byte(esd_pkg::CHAR_BACKSLASH);
        push_byte(SIMPLE_CHARS[$urandom_range(0, 10)]);
      end else if (kind < 56) begin
        push_byte(esd_pkg::CHAR_BACKSLASH);
        push_byte(esd_pkg::CHAR_X);
        repeat ($urandom_range(1, esd_pkg::X_HEX_DIGITS_DEF))
          push_byte(hex_char($urandom_range(0, 15)));
      end else if (kind < 70) begin
        push_byte(esd_pkg::CHAR_BACKSLASH);
        push_byte(esd_pkg::CHAR_U);
        repeat ($urandom_range(1, esd_pkg::U_HEX_DIGITS_DEF))
          push_byte(hex_char($urandom_range(0, 15)));
      end else if (kind < 84) begin
        push_byte(esd_pkg::CHAR_BACKSLASH);
        repeat ($urandom_range(1, 3)) push_byte(oct_char());
      end else if (kind < 91) begin
        push_byte(esd_pkg::CHAR_BACKSLASH);
        push_byte(8'($urandom));
      end else if (kind < 96) begin
        push_byte(esd_pkg::CHAR_BACKSLASH);
        push_byte($urandom_range(0, 1) ? esd_pkg::CHAR_X : esd_pkg::CHAR_U);
        push_byte(8'($urandom));
      end else begin
        case ($urandom_range(0, 4))
          1: push_byte(esd_pkg::CHAR_BACKSLASH);
          2: begin
            push_byte(esd_pkg::CHAR_BACKSLASH);
            push_byte($urandom_range(0, 1) ? esd_pkg::CHAR_X : esd_pkg::CHAR_U);
          end
          3: begin
            push_byte(esd_pkg::CHAR_BACKSLASH);
            push_byte(oct_char());
          end
          4: begin
            push_byte(esd_pkg::CHAR_BACKSLASH);
            push_byte(esd_pkg::CHAR_X);
            push_byte(hex_char($urandom_range(0, 15)));
          end
          default: ;
        endcase
        push_end();
      end
    end
  endtask

  // Source stays quiet until every predicted result has come back.
  task automatic drain();
    while (text_q.size() != 0 || s_axis_tvalid || decoded_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_narrow(input logic v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    write_narrow(1'b0);
    @(negedge clk);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_str("\\xg");       // hex escape with no digit
    push_str("\\q");        // unknown escape letter
    push_str("\\");
    push_end();
    push_str("\\x");
    push_end();
    push_str("\\uFFF");
    push_str("\\12");       // end of text after some digits
    push_end();
    push_str("\\x4\\n");    // numeric escape closed by a new escape
    push_end();             // end of text with nothing open
    drain();

    write_narrow(1'b1);
    @(negedge clk);
    push_str("\\777");
    push_str("\\377");
    push_str("\\u100");
    push_str("\\xfZ");      // numeric escape closed by an ordinary byte
    add_random(300);
    drain();

    write_narrow(1'b0);
    tx_idle_pct <= 60;
    @(negedge clk);
    add_random(350);
    drain();

    write_narrow(1'b1);
    tx_idle_pct  <= 0;
    rx_stall_pct <= 60;
    @(negedge clk);
    add_random(350);
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    drain();

    write_narrow(1'b0);
    tx_idle_pct  <= 8;
    rx_stall_pct <= 8;
    @(negedge clk);
    add_random(350);
    drain();

    $display("Sent %0d text requests (%0d ends of text) in wide and narrow mode",
             req_cnt, eot_cnt);
    $display("under five flow control patterns; %0d results: %0d ok, %0d invalid, %0d range.",
             result_cnt, ok_cnt, invalid_cnt, range_cnt);
    if (fail_cnt == 0 && decoded_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fail_cnt, decoded_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
